// ===== hdl/hm3_pkg.sv =====
`default_nettype none
package hm3_pkg;

	// MurmurHash3 x64_128 mixing constants
	localparam logic [63:0] MIX_C1     = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MIX_C2     = 64'h4cf5_ad43_2745_937f;
	localparam logic [63:0] ADD_FIRST  = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] ADD_SECOND = 64'h0000_0000_3849_5ab5;
	localparam logic [63:0] FIN_M1     = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] FIN_M2     = 64'hc4ce_b9fe_1a85_ec53;

	localparam logic [4:0] BLOCK_BYTES = 5'd16;
	localparam int         WORD_BYTES  = 8;

	localparam int QUEUE_DEPTH_DEF = 2;

	// One classified block, as it waits in the queue
	typedef struct packed {
		logic [63:0] k_first;
		logic [63:0] k_second;
		logic [4:0]  count;
		logic        full;
		logic        lane_first;
		logic        lane_second;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} mul_rsp_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] xshift33(input logic [63:0] x);
		return x ^ (x >> 33);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/hm3_block_if.sv =====
`default_nettype none
interface hm3_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low_word;
	logic [63:0] block_high_word;
	logic [4:0]  valid_bytes;
	logic        is_last;

	modport source(output valid, block_low_word, block_high_word, valid_bytes, is_last,
		input ready);
	modport sink(input valid, block_low_word, block_high_word, valid_bytes, is_last,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/hm3_hash_if.sv =====
`default_nettype none
interface hm3_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_first;
	logic [63:0] hash_second;

	modport source(output valid, hash_first, hash_second, input ready);
	modport sink(input valid, hash_first, hash_second, output ready);
endinterface
`default_nettype wire

// ===== hdl/hm3_seed_if.sv =====
`default_nettype none
interface hm3_seed_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_seed;

	modport source(output valid, hash_seed, input ready);
	modport sink(input valid, hash_seed, output ready);
endinterface
`default_nettype wire

// ===== hdl/hm3_front.sv =====
`default_nettype none
module hm3_front (
	hm3_block_if.sink        blk,
	input  logic             q_full,
	output logic             push,
	output hm3_pkg::entry_t  push_data
);
	import hm3_pkg::*;

	logic [4:0]  cnt;
	logic [63:0] mask_lo;
	logic [63:0] mask_hi;

	// clamp oversized counts to a full block
	assign cnt = (blk.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : blk.valid_bytes;

	always_comb begin
		for (int i = 0; i < WORD_BYTES; i++) begin
			mask_lo[8*i +: 8] = {8{cnt > 5'(i)}};
			mask_hi[8*i +: 8] = {8{cnt > 5'(i + WORD_BYTES)}};
		end
	end

	always_comb begin
		push_data.k_first     = blk.block_low_word & mask_lo;
		push_data.k_second    = blk.block_high_word & mask_hi;
		push_data.count       = cnt;
		push_data.full        = (cnt == BLOCK_BYTES);
		push_data.lane_first  = (cnt != 5'd0);
		push_data.lane_second = (cnt > 5'(WORD_BYTES));
		push_data.last        = blk.is_last;
	end

	assign blk.ready = !q_full;
	assign push      = blk.valid && !q_full;

endmodule
`default_nettype wire

// ===== hdl/hm3_fifo.sv =====
`default_nettype none
module hm3_fifo #(
	parameter int DEPTH = hm3_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hm3_pkg::entry_t  push_data,
	output logic             full,
	input  logic             pop,
	output hm3_pkg::entry_t  pop_data,
	output logic             empty
);
	import hm3_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hm3_mul.sv =====
`default_nettype none
module hm3_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  hm3_pkg::mul_req_t  req,
	output hm3_pkg::mul_rsp_t  rsp
);
	import hm3_pkg::*;

	// low 64 bits of a 64x64 product from three 32x32 partial products
	typedef enum logic [1:0] {MP_LL, MP_HL, MP_LH, MP_SUM} phase_t;

	phase_t      phase_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] prod_q;
	logic [63:0] sum_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod_d;

	assign op_a   = (phase_q == MP_HL) ? a_q[63:32] : a_q[31:0];
	assign op_b   = (phase_q == MP_LH) ? b_q[63:32] : b_q[31:0];
	assign prod_d = 64'(op_a) * 64'(op_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_LL;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			prod_q  <= '0;
			sum_q   <= '0;
		end else begin
			// flag the product for one cycle after the last sum step
			done_q <= busy_q && (phase_q == MP_SUM);
			if (!busy_q) begin
				if (req.start) begin
					a_q     <= req.a;
					b_q     <= req.b;
					busy_q  <= 1'b1;
					phase_q <= MP_LL;
				end
			end else begin
				prod_q <= prod_d;
				case (phase_q)
					MP_LL: begin
						phase_q <= MP_HL;
					end
					MP_HL: begin
						sum_q   <= prod_q;
						phase_q <= MP_LH;
					end
					MP_LH: begin
						sum_q   <= {sum_q[63:32] + prod_q[31:0], sum_q[31:0]};
						phase_q <= MP_SUM;
					end
					MP_SUM: begin
						sum_q   <= {sum_q[63:32] + prod_q[31:0], sum_q[31:0]};
						busy_q  <= 1'b0;
						phase_q <= MP_LL;
					end
					default: begin
						phase_q <= MP_LL;
					end
				endcase
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = sum_q;

endmodule
`default_nettype wire

// ===== hdl/hm3_core.sv =====
`default_nettype none
module hm3_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        seed,
	input  logic               q_empty,
	input  hm3_pkg::entry_t    q_data,
	output logic               pop,
	output hm3_pkg::mul_req_t  mul_req,
	input  hm3_pkg::mul_rsp_t  mul_rsp,
	hm3_hash_if.source         hash
);
	import hm3_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_L1A, S_L1B, S_B1_ROT, S_B1_MUL5, S_B1_ADD,
		S_L2A, S_L2B, S_B2_ROT, S_B2_MUL5, S_B2_ADD,
		S_F_XOR, S_F_ADD1, S_F_ADD2, S_FM1A, S_FM1B, S_FM2A, S_FM2B,
		S_F_ADD3, S_F_ADD4, S_OUT
	} state_t;

	state_t      state_q;
	entry_t      ent_q;
	logic [63:0] acc1_q;
	logic [63:0] acc2_q;
	logic [63:0] total_q;
	logic [63:0] w_q;
	logic        in_msg_q;
	logic        issued_q;
	logic        out_valid_q;
	logic [63:0] out_first_q;
	logic [63:0] out_second_q;
	logic        mul_state;
	logic        out_free;

	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || hash.ready;

	always_comb begin
		mul_state = 1'b1;
		mul_req.a = '0;
		mul_req.b = '0;
		case (state_q)
			S_L1A: begin
				mul_req.a = ent_q.k_first;
				mul_req.b = MIX_C1;
			end
			S_L1B: begin
				mul_req.a = rotl64(w_q, 31);
				mul_req.b = MIX_C2;
			end
			S_L2A: begin
				mul_req.a = ent_q.k_second;
				mul_req.b = MIX_C2;
			end
			S_L2B: begin
				mul_req.a = rotl64(w_q, 33);
				mul_req.b = MIX_C1;
			end
			S_FM1A: begin
				mul_req.a = xshift33(acc1_q);
				mul_req.b = FIN_M1;
			end
			S_FM2A: begin
				mul_req.a = xshift33(acc2_q);
				mul_req.b = FIN_M1;
			end
			S_FM1B, S_FM2B: begin
				mul_req.a = xshift33(w_q);
				mul_req.b = FIN_M2;
			end
			default: begin
				mul_state = 1'b0;
			end
		endcase
		mul_req.start = mul_state && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ent_q        <= '0;
			acc1_q       <= '0;
			acc2_q       <= '0;
			total_q      <= '0;
			w_q          <= '0;
			in_msg_q     <= 1'b0;
			issued_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_first_q  <= '0;
			out_second_q <= '0;
		end else begin
			if (mul_req.start) begin
				issued_q <= 1'b1;
			end else if (mul_rsp.done) begin
				issued_q <= 1'b0;
			end
			// a new hash word replaces one taken in the same cycle
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && hash.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pop) begin
						ent_q    <= q_data;
						in_msg_q <= 1'b1;
						// reload the halves at message start
						if (!in_msg_q) begin
							acc1_q  <= {32'd0, seed};
							acc2_q  <= {32'd0, seed};
							total_q <= {59'd0, q_data.count};
						end else begin
							total_q <= total_q + {59'd0, q_data.count};
						end
						if (q_data.lane_first) begin
							state_q <= S_L1A;
						end else if (q_data.lane_second) begin
							state_q <= S_L2A;
						end else if (q_data.last) begin
							state_q <= S_F_XOR;
						end
					end
				end
				S_L1A: begin
					if (mul_rsp.done) begin
						w_q     <= mul_rsp.p;
						state_q <= S_L1B;
					end
				end
				S_L1B: begin
					if (mul_rsp.done) begin
						acc1_q <= acc1_q ^ mul_rsp.p;
						if (ent_q.full) begin
							state_q <= S_B1_ROT;
						end else if (ent_q.lane_second) begin
							state_q <= S_L2A;
						end else begin
							state_q <= ent_q.last ? S_F_XOR : S_IDLE;
						end
					end
				end
				S_B1_ROT: begin
					acc1_q  <= rotl64(acc1_q, 27) + acc2_q;
					state_q <= S_B1_MUL5;
				end
				S_B1_MUL5: begin
					acc1_q  <= acc1_q + {acc1_q[61:0], 2'b00};
					state_q <= S_B1_ADD;
				end
				S_B1_ADD: begin
					acc1_q  <= acc1_q + ADD_FIRST;
					state_q <= S_L2A;
				end
				S_L2A: begin
					if (mul_rsp.done) begin
						w_q     <= mul_rsp.p;
						state_q <= S_L2B;
					end
				end
				S_L2B: begin
					if (mul_rsp.done) begin
						acc2_q <= acc2_q ^ mul_rsp.p;
						if (ent_q.full) begin
							state_q <= S_B2_ROT;
						end else begin
							state_q <= ent_q.last ? S_F_XOR : S_IDLE;
						end
					end
				end
				S_B2_ROT: begin
					acc2_q  <= rotl64(acc2_q, 31) + acc1_q;
					state_q <= S_B2_MUL5;
				end
				S_B2_MUL5: begin
					acc2_q  <= acc2_q + {acc2_q[61:0], 2'b00};
					state_q <= S_B2_ADD;
				end
				S_B2_ADD: begin
					acc2_q  <= acc2_q + ADD_SECOND;
					state_q <= ent_q.last ? S_F_XOR : S_IDLE;
				end
				S_F_XOR: begin
					acc1_q  <= acc1_q ^ total_q;
					acc2_q  <= acc2_q ^ total_q;
					state_q <= S_F_ADD1;
				end
				S_F_ADD1: begin
					acc1_q  <= acc1_q + acc2_q;
					state_q <= S_F_ADD2;
				end
				S_F_ADD2: begin
					acc2_q  <= acc2_q + acc1_q;
					state_q <= S_FM1A;
				end
				S_FM1A: begin
					if (mul_rsp.done) begin
						w_q     <= mul_rsp.p;
						state_q <= S_FM1B;
					end
				end
				S_FM1B: begin
					if (mul_rsp.done) begin
						acc1_q  <= xshift33(mul_rsp.p);
						state_q <= S_FM2A;
					end
				end
				S_FM2A: begin
					if (mul_rsp.done) begin
						w_q     <= mul_rsp.p;
						state_q <= S_FM2B;
					end
				end
				S_FM2B: begin
					if (mul_rsp.done) begin
						acc2_q  <= xshift33(mul_rsp.p);
						state_q <= S_F_ADD3;
					end
				end
				S_F_ADD3: begin
					acc1_q  <= acc1_q + acc2_q;
					state_q <= S_F_ADD4;
				end
				S_F_ADD4: begin
					acc2_q  <= acc2_q + acc1_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_first_q  <= acc1_q;
						out_second_q <= acc2_q;
						in_msg_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign hash.valid       = out_valid_q;
	assign hash.hash_first  = out_first_q;
	assign hash.hash_second = out_second_q;

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> issued_q)
		else $error("multiplier result without a request");

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("hash word raised outside the output step");

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_valid_q && !hash.ready |=> state_q == S_OUT)
		else $error("final hash overwrote a word not yet taken");

	a_pop_opens: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> in_msg_q)
		else $error("block taken without opening a message");

endmodule
`default_nettype wire

// ===== hdl/murmur3_x64_128_hash_top.sv =====
`default_nettype none
// Streaming MurmurHash3 x64_128. Each word on blk is one 16-byte block (bytes 0..7 in
// block_low_word, 8..15 in block_high_word, byte 0 in the low bits), a valid-byte count
// and a last flag; counts above 16 act as 16, bytes beyond the count are ignored. A
// message ends with is_last, and then one 128-bit hash word leaves on hash. The seed on
// cfg is latched at once and loaded into both hash halves when the next message starts.
// Blocks are classified and masked on entry and wait in a small queue (QUEUE_DEPTH
// entries) in front of a sequencer that does the mixing on one shared 32x32
// multiplier; each 64-bit product is built from three 32x32 partial products. A full
// block runs both lanes with their rotate, times-5 and add steps, a short block only
// the first lane (up to 8 bytes) or both lanes without them, an empty block none.
// The last block adds finalization; the output register holds the hash until taken.
module murmur3_x64_128_hash_top #(
	parameter int QUEUE_DEPTH = hm3_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hm3_block_if.sink   blk,
	hm3_hash_if.source  hash,
	hm3_seed_if.sink    cfg
);
	import hm3_pkg::*;

	logic [31:0] seed_q;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	entry_t      push_data;
	entry_t      pop_data;
	mul_req_t    mul_req;
	mul_rsp_t    mul_rsp;

	// seed register: always ready, one word written per handshake
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid) begin
			seed_q <= cfg.hash_seed;
		end
	end

	// front: clamp count, mask unused bytes, tag which lanes run
	hm3_front u_front (
		.blk       (blk),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// queue decouples block intake from mixing
	hm3_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// back: mixing and finalization sequencer with output register
	hm3_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.seed    (seed_q),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp),
		.hash    (hash)
	);

	// shared multi-cycle 64x64 multiplier, low half only
	hm3_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule
`default_nettype wire
